// ----- hdl/dltq_pkg.sv -----
// ---------------------------------------------------------------------------
// dltq_pkg: shared types and codes for the delta list timer queue
// Entry layout, cell control codes, operation and result kinds.
// ---------------------------------------------------------------------------
`default_nettype none
package dltq_pkg;

   localparam int MAX_TIMERS = 16;
   localparam int IDX_W = $clog2(MAX_TIMERS);
   localparam int CNT_W = IDX_W + 1;

   // operation codes
   localparam logic [1:0] OP_START  = 2'd0;
   localparam logic [1:0] OP_CANCEL = 2'd1;
   localparam logic [1:0] OP_MATCH  = 2'd2;
   localparam logic [1:0] OP_TICK   = 2'd3;

   // result kinds
   localparam logic [2:0] K_STARTED   = 3'd0;
   localparam logic [2:0] K_FULL      = 3'd1;
   localparam logic [2:0] K_CANCELLED = 3'd2;
   localparam logic [2:0] K_INACTIVE  = 3'd3;
   localparam logic [2:0] K_FOUND     = 3'd4;
   localparam logic [2:0] K_NO_MATCH  = 3'd5;
   localparam logic [2:0] K_EXPIRED   = 3'd6;
   localparam logic [2:0] K_TICK_DONE = 3'd7;

   // cell control codes
   localparam logic [2:0] C_HOLD      = 3'd0;
   localparam logic [2:0] C_LEFT      = 3'd1;
   localparam logic [2:0] C_LEFT_SUB  = 3'd2;
   localparam logic [2:0] C_NEW       = 3'd3;
   localparam logic [2:0] C_RIGHT     = 3'd4;
   localparam logic [2:0] C_RIGHT_ADD = 3'd5;
   localparam logic [2:0] C_DEC       = 3'd6;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] slot;
      logic [31:0]      delta;
      logic [15:0]      id;
      logic [7:0]       handler;
      logic [31:0]      tag;
   } entry_type;

   typedef struct packed {
      logic [2:0]  code;
      logic [31:0] adj;
   } cell_ctl_type;

endpackage
`default_nettype wire

// ----- hdl/dltq_cell.sv -----
// ---------------------------------------------------------------------------
// dltq_cell: one queue position of the delta list
// Holds one entry; shifts with its neighbors on insert and unlink.
// ---------------------------------------------------------------------------
`default_nettype none
module dltq_cell (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire dltq_pkg::cell_ctl_type ctl,
   input  wire dltq_pkg::entry_type    left_entry,
   input  wire dltq_pkg::entry_type    right_entry,
   input  wire dltq_pkg::entry_type    new_entry,
   output dltq_pkg::entry_type         entry
);
   import dltq_pkg::*;

   entry_type entry_ff, entry_in;

   // next entry by control code
   always_comb begin
      entry_in = entry_ff;
      case (ctl.code)
         C_LEFT:      entry_in = left_entry;
         C_LEFT_SUB:  begin
            entry_in = left_entry;
            entry_in.delta = left_entry.delta - ctl.adj;
         end
         C_NEW:       entry_in = new_entry;
         C_RIGHT:     entry_in = right_entry;
         C_RIGHT_ADD: begin
            entry_in = right_entry;
            entry_in.delta = right_entry.delta + ctl.adj;
         end
         C_DEC:       entry_in.delta = entry_ff.delta - 32'd1;
         default:     entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry = entry_ff;

endmodule
`default_nettype wire

// ----- hdl/delta_list_timer_queue.sv -----
// ---------------------------------------------------------------------------
// delta_list_timer_queue: timer queue kept as a chain of delta cells
// Start walks the chain to its insert point; cancel and match act on all
// cells at once; tick unlinks each expired head entry in turn.
// ---------------------------------------------------------------------------
//  channel | ports  | tuser | tdata fields (low bit up)
//  request | req_*  | op    | delay_ms, timer_id, handler, tag, slot
//  result  | rsp_*  | kind  | out_slot, remainder_ms, out_id, out_handler,
//          |        |       | out_tag; tlast = last
// Cancel and match are answered from the idle state. Start passes the
// entries on its walk one at a time, then inserts; a tick emits each
// expired entry in turn, then the tick result. No request is taken until
// start or tick is back in idle. Each result needs the output register free,
// so a stalled result channel holds the sequencer. Synchronous reset
// empties the chain; no clearing pass.
`default_nettype none
module delta_list_timer_queue (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // op[1:0]
   input  wire logic [1:0]  req_tuser,
   // delay_ms[31:0], timer_id[47:32], handler[55:48], tag[87:56],
   // slot[91:88], zero fill
   input  wire logic [95:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // kind[2:0]
   output logic [2:0]       rsp_tuser,
   // out_slot[3:0], remainder_ms[35:4], out_id[51:36],
   // out_handler[59:52], out_tag[91:60], zero fill
   output logic [95:0]      rsp_tdata,
   output logic             rsp_tlast
);
   import dltq_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_INS  = 2'd1;
   localparam logic [1:0] S_TICK = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [31:0]      nd_ff, nd_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   entry_type        new_ff, new_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_kind_ff, rsp_kind_in;
   logic [95:0]      rsp_data_ff, rsp_data_in;
   logic             rsp_last_ff, rsp_last_in;

   entry_type        cells [MAX_TIMERS];
   cell_ctl_type     ctl [MAX_TIMERS];
   entry_type        empty_entry;

   logic [1:0]       r_op;
   logic [31:0]      r_delay;
   logic [15:0]      r_id;
   logic [7:0]       r_handler;
   logic [31:0]      r_tag;
   logic [IDX_W-1:0] r_slot;

   logic             out_free;
   logic [MAX_TIMERS-1:0] used;
   logic [IDX_W-1:0] free_slot;
   logic             hit, found;
   logic [IDX_W-1:0] hit_pos, found_pos;
   entry_type        cur;

   assign r_op      = req_tuser;
   assign r_delay   = req_tdata[31:0];
   assign r_id      = req_tdata[47:32];
   assign r_handler = req_tdata[55:48];
   assign r_tag     = req_tdata[87:56];
   assign r_slot    = req_tdata[88 +: IDX_W];

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && out_free;

   always_comb begin
      empty_entry = '0;
   end

   // slot usage, lowest free slot, cancel and match searches
   always_comb begin
      used = '0;
      free_slot = '0;
      hit = 1'b0;
      hit_pos = '0;
      found = 1'b0;
      found_pos = '0;
      for (int i = 0; i < MAX_TIMERS; i++) begin
         if (cells[i].valid) begin
            used[cells[i].slot] = 1'b1;
         end
      end
      for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
         if (!used[i]) begin
            free_slot = IDX_W'(i);
         end
         if (cells[i].valid && cells[i].slot == r_slot) begin
            hit = 1'b1;
            hit_pos = IDX_W'(i);
         end
         if (cells[i].valid && cells[i].id == r_id) begin
            found = 1'b1;
            found_pos = IDX_W'(i);
         end
      end
   end

   // entry at the walk pointer
   always_comb begin
      cur = empty_entry;
      if (!pos_ff[IDX_W]) begin
         cur = cells[pos_ff[IDX_W-1:0]];
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      nd_in        = nd_ff;
      pos_in       = pos_ff;
      new_in       = new_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      for (int i = 0; i < MAX_TIMERS; i++) begin
         ctl[i].code = C_HOLD;
         ctl[i].adj  = '0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               rsp_data_in = '0;
               rsp_last_in = 1'b1;
               unique case (r_op)
                  OP_START: begin
                     if (cells[MAX_TIMERS-1].valid) begin
                        rsp_valid_in = 1'b1;
                        rsp_kind_in  = K_FULL;
                     end else begin
                        new_in.valid   = 1'b1;
                        new_in.slot    = free_slot;
                        new_in.delta   = r_delay;
                        new_in.id      = r_id;
                        new_in.handler = r_handler;
                        new_in.tag     = r_tag;
                        nd_in  = r_delay;
                        pos_in = '0;
                        state_in = S_INS;
                     end
                  end
                  OP_CANCEL: begin
                     rsp_valid_in = 1'b1;
                     if (hit) begin
                        rsp_kind_in = K_CANCELLED;
                        rsp_data_in[0 +: IDX_W] = r_slot;
                        rsp_data_in[35:4] = cells[hit_pos].delta;
                        for (int i = 0; i < MAX_TIMERS; i++) begin
                           if (IDX_W'(i) == hit_pos) begin
                              ctl[i].code = C_RIGHT_ADD;
                              ctl[i].adj  = cells[hit_pos].delta;
                           end else if (IDX_W'(i) > hit_pos) begin
                              ctl[i].code = C_RIGHT;
                           end
                        end
                     end else begin
                        rsp_kind_in = K_INACTIVE;
                     end
                  end
                  OP_MATCH: begin
                     rsp_valid_in = 1'b1;
                     if (found) begin
                        rsp_kind_in = K_FOUND;
                        rsp_data_in[0 +: IDX_W] = cells[found_pos].slot;
                     end else begin
                        rsp_kind_in = K_NO_MATCH;
                     end
                  end
                  OP_TICK: state_in = S_TICK;
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_INS: begin
            // pass entries whose total expiry is not later than the new one
            if (cur.valid && cur.delta <= nd_ff) begin
               nd_in  = nd_ff - cur.delta;
               new_in.delta = nd_ff - cur.delta;
               pos_in = pos_ff + CNT_W'(1);
            end else if (out_free) begin
               for (int i = 0; i < MAX_TIMERS; i++) begin
                  if (CNT_W'(i) == pos_ff) begin
                     ctl[i].code = C_NEW;
                  end else if (CNT_W'(i) == pos_ff + CNT_W'(1)) begin
                     ctl[i].code = C_LEFT_SUB;
                     ctl[i].adj  = nd_ff;
                  end else if (CNT_W'(i) > pos_ff) begin
                     ctl[i].code = C_LEFT;
                  end
               end
               rsp_valid_in = 1'b1;
               rsp_last_in  = 1'b1;
               rsp_data_in  = '0;
               rsp_kind_in  = K_STARTED;
               rsp_data_in[0 +: IDX_W] = new_ff.slot;
               state_in = S_IDLE;
            end
         end
         S_TICK: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '0;
               if (cells[0].valid && cells[0].delta == 32'd0) begin
                  rsp_last_in = 1'b0;
                  rsp_kind_in = K_EXPIRED;
                  rsp_data_in[0 +: IDX_W] = cells[0].slot;
                  rsp_data_in[51:36] = cells[0].id;
                  rsp_data_in[59:52] = cells[0].handler;
                  rsp_data_in[91:60] = cells[0].tag;
                  for (int i = 0; i < MAX_TIMERS; i++) begin
                     ctl[i].code = C_RIGHT;
                  end
               end else begin
                  rsp_last_in = 1'b1;
                  rsp_kind_in = K_TICK_DONE;
                  if (cells[0].valid) begin
                     ctl[0].code = C_DEC;
                  end
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // cell chain
   for (genvar g = 0; g < MAX_TIMERS; g++) begin : g_cell
      dltq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl[g]),
         .left_entry  ((g == 0) ? empty_entry : cells[(g == 0) ? 0 : g - 1]),
         .right_entry ((g == MAX_TIMERS - 1) ? empty_entry
                       : cells[(g == MAX_TIMERS - 1) ? g : g + 1]),
         .new_entry   (new_ff),
         .entry       (cells[g])
      );
   end

   always_ff @(posedge clock) begin
      nd_ff       <= nd_in;
      pos_ff      <= pos_in;
      new_ff      <= new_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
`default_nettype wire

// ----- bench/delta_list_timer_queue_tb.sv -----
// ---------------------------------------------------------------------------
// delta_list_timer_queue_tb: self-checking bench for the timer queue
// Drives start, cancel, match and tick requests (a directed table, then
// random traffic) with random idling on both channels. Every result
// transfer is compared field by field against a queue model kept here.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module delta_list_timer_queue_tb;
   import dltq_pkg::*;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] delay_ms;
      logic [15:0] timer_id;
      logic [7:0]  handler;
      logic [31:0] tag;
      logic [3:0]  slot;
   } timer_req_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  slot;
      logic [31:0] remainder_ms;
      logic [15:0] id;
      logic [7:0]  handler;
      logic [31:0] tag;
      logic        last;
   } timer_rsp_type;

   // directed row: request plus an optional typed-in answer
   typedef struct {
      timer_req_type req;
      bit            has_answer;
      timer_rsp_type answer;
   } table_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;
   logic [95:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [2:0]  rsp_tuser;
   logic [95:0] rsp_tdata;
   logic        rsp_tlast;

   delta_list_timer_queue dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tuser(rsp_tuser),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // queue model state
   logic [3:0]  chain[MAX_TIMERS];
   int          depth_used;
   logic [31:0] delta_of[MAX_TIMERS];
   logic [15:0] id_of[MAX_TIMERS];
   logic [7:0]  handler_of[MAX_TIMERS];
   logic [31:0] tag_of[MAX_TIMERS];
   bit          busy_slot[MAX_TIMERS];

   timer_rsp_type pending_rsp[$];
   int            error_count = 0;
   bit            no_idle = 0;

   function automatic timer_rsp_type mk_rsp(logic [2:0] k, logic [3:0] s,
                                            logic [31:0] r, logic l);
      timer_rsp_type x;
      x = '0;
      x.kind = k;
      x.slot = s;
      x.remainder_ms = r;
      x.last = l;
      return x;
   endfunction

   function automatic logic [31:0] remove_at(int pos);
      logic [3:0]  s;
      logic [31:0] d;
      s = chain[pos];
      d = delta_of[s];
      if (pos + 1 < depth_used) delta_of[chain[pos+1]] += d;
      for (int i = pos; i + 1 < depth_used; i++) chain[i] = chain[i+1];
      depth_used--;
      busy_slot[s] = 0;
      return d;
   endfunction

   // apply one request to the model and queue the results it causes
   task automatic predict_queue(timer_req_type q);
      int            s, pos;
      logic [31:0]   nd;
      logic [32:0]   sum;
      bit            done;
      timer_rsp_type x;
      done = 0;
      case (q.op)
         OP_START: begin
            s = MAX_TIMERS;
            if (depth_used < MAX_TIMERS)
               for (int i = MAX_TIMERS - 1; i >= 0; i--) if (!busy_slot[i]) s = i;
            if (s >= MAX_TIMERS) begin
               pending_rsp.push_back(mk_rsp(K_FULL, 0, 0, 1));
            end else begin
               pos = 0; nd = q.delay_ms; sum = 0;
               for (int i = 0; i < depth_used && !done; i++) begin
                  sum += delta_of[chain[i]];
                  if (sum > {1'b0, q.delay_ms}) done = 1;
                  else begin
                     nd -= delta_of[chain[i]];
                     pos = i + 1;
                  end
               end
               for (int i = depth_used; i > pos; i--) chain[i] = chain[i-1];
               chain[pos] = 4'(s);
               depth_used++;
               if (pos + 1 < depth_used) delta_of[chain[pos+1]] -= nd;
               delta_of[s] = nd;
               id_of[s] = q.timer_id;
               handler_of[s] = q.handler;
               tag_of[s] = q.tag;
               busy_slot[s] = 1;
               pending_rsp.push_back(mk_rsp(K_STARTED, 4'(s), 0, 1));
            end
         end
         OP_CANCEL: begin
            if (busy_slot[q.slot]) begin
               for (int i = 0; i < depth_used && !done; i++)
                  if (chain[i] == q.slot) begin
                     pending_rsp.push_back(mk_rsp(K_CANCELLED, q.slot,
                                                  remove_at(i), 1));
                     done = 1;
                  end
            end
            if (!done) pending_rsp.push_back(mk_rsp(K_INACTIVE, 0, 0, 1));
         end
         OP_MATCH: begin
            for (int i = 0; i < depth_used && !done; i++)
               if (id_of[chain[i]] == q.timer_id) begin
                  pending_rsp.push_back(mk_rsp(K_FOUND, chain[i], 0, 1));
                  done = 1;
               end
            if (!done) pending_rsp.push_back(mk_rsp(K_NO_MATCH, 0, 0, 1));
         end
         default: begin
            while (depth_used > 0 && delta_of[chain[0]] == 0) begin
               s = chain[0];
               x = mk_rsp(K_EXPIRED, 4'(s), 0, 0);
               x.id = id_of[s];
               x.handler = handler_of[s];
               x.tag = tag_of[s];
               pending_rsp.push_back(x);
               void'(remove_at(0));
            end
            if (depth_used > 0) delta_of[chain[0]] -= 1;
            pending_rsp.push_back(mk_rsp(K_TICK_DONE, 0, 0, 1));
         end
      endcase
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // result channel: random stall, compare every transfer
   timer_rsp_type got_rsp, want_rsp;
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_rsp.kind         = rsp_tuser;
            got_rsp.slot         = rsp_tdata[3:0];
            got_rsp.remainder_ms = rsp_tdata[35:4];
            got_rsp.id           = rsp_tdata[51:36];
            got_rsp.handler      = rsp_tdata[59:52];
            got_rsp.tag          = rsp_tdata[91:60];
            got_rsp.last         = rsp_tlast;
            if (pending_rsp.size() == 0) begin
               report_mismatch("unexpected result kind", got_rsp.kind, 0);
            end else begin
               want_rsp = pending_rsp.pop_front();
               if (got_rsp.kind != want_rsp.kind)
                  report_mismatch("kind", got_rsp.kind, want_rsp.kind);
               if (got_rsp.slot != want_rsp.slot)
                  report_mismatch("out_slot", got_rsp.slot, want_rsp.slot);
               if (got_rsp.remainder_ms != want_rsp.remainder_ms)
                  report_mismatch("remainder_ms", got_rsp.remainder_ms,
                                  want_rsp.remainder_ms);
               if (got_rsp.id != want_rsp.id)
                  report_mismatch("out_id", got_rsp.id, want_rsp.id);
               if (got_rsp.handler != want_rsp.handler)
                  report_mismatch("out_handler", got_rsp.handler, want_rsp.handler);
               if (got_rsp.tag != want_rsp.tag)
                  report_mismatch("out_tag", got_rsp.tag, want_rsp.tag);
               if (got_rsp.last != want_rsp.last)
                  report_mismatch("last", got_rsp.last, want_rsp.last);
            end
         end
         rsp_tready <= no_idle || ($urandom_range(99) >= 27);
      end
   end

   // one request transfer; the table answer, when given, is checked
   // against the prediction so the typed row and the model agree
   task automatic send_request(timer_req_type q, bit has_answer,
                               timer_rsp_type answer);
      int idle_cycles;
      idle_cycles = 0;
      while (!no_idle && $urandom_range(99) < 27) idle_cycles++;
      // valid stays high from one transfer to the next unless idling
      if (idle_cycles > 0) begin
         req_tvalid <= 1'b0;
         repeat (idle_cycles) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= q.op;
      req_tdata <= {4'b0000, q.slot, q.tag, q.handler, q.timer_id, q.delay_ms};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_queue(q);
      if (has_answer && pending_rsp[pending_rsp.size()-1] != answer)
         report_mismatch("table answer kind", answer.kind,
                         pending_rsp[pending_rsp.size()-1].kind);
   endtask

   function automatic timer_req_type mk_req(logic [1:0] op, logic [31:0] d,
                                            logic [15:0] id, logic [7:0] h,
                                            logic [31:0] t, logic [3:0] s);
      timer_req_type q;
      q.op = op; q.delay_ms = d; q.timer_id = id;
      q.handler = h; q.tag = t; q.slot = s;
      return q;
   endfunction

   function automatic table_row_type row(timer_req_type q, bit a, timer_rsp_type r);
      table_row_type x;
      x.req = q; x.has_answer = a; x.answer = r;
      return x;
   endfunction

   timer_req_type rq;
   table_row_type steps[$];
   int            live;
   int            wait_cycles;

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      depth_used = 0;
      for (int i = 0; i < MAX_TIMERS; i++) begin
         busy_slot[i] = 0; chain[i] = 0; delta_of[i] = 0;
         id_of[i] = 0; handler_of[i] = 0; tag_of[i] = 0;
      end
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // directed table
      steps.push_back(row(mk_req(OP_TICK, 0, 0, 0, 0, 0), 1,
                          mk_rsp(K_TICK_DONE, 0, 0, 1)));
      steps.push_back(row(mk_req(OP_CANCEL, 0, 0, 0, 0, 4'hF), 1,
                          mk_rsp(K_INACTIVE, 0, 0, 1)));
      steps.push_back(row(mk_req(OP_MATCH, 0, 16'hFFFF, 0, 0, 0), 1,
                          mk_rsp(K_NO_MATCH, 0, 0, 1)));
      steps.push_back(row(mk_req(OP_START, 0, 16'hFFFF, 8'hFF, '1, 4'hF), 1,
                          mk_rsp(K_STARTED, 0, 0, 1)));
      steps.push_back(row(mk_req(OP_START, '1, 0, 0, 0, 0), 1,
                          mk_rsp(K_STARTED, 1, 0, 1)));
      steps.push_back(row(mk_req(OP_START, 0, 16'h1234, 8'h5A, 32'hA5A5A5A5, 0),
                          1, mk_rsp(K_STARTED, 2, 0, 1)));
      steps.push_back(row(mk_req(OP_MATCH, 0, 16'hFFFF, 0, 0, 0), 1,
                          mk_rsp(K_FOUND, 0, 0, 1)));
      steps.push_back(row(mk_req(OP_START, 3, 16'h0003, 8'h03, 3, 0), 0, '0));
      steps.push_back(row(mk_req(OP_START, 3, 16'h0004, 8'h04, 4, 0), 0, '0));
      steps.push_back(row(mk_req(OP_CANCEL, 0, 0, 0, 0, 1), 1,
                          mk_rsp(K_CANCELLED, 1, 32'hFFFFFFFC, 1)));
      steps.push_back(row(mk_req(OP_TICK, 0, 0, 0, 0, 0), 0, '0));
      steps.push_back(row(mk_req(OP_TICK, 0, 0, 0, 0, 0), 0, '0));
      for (int i = 0; i < 14; i++)
         steps.push_back(row(mk_req(OP_START, 5, 16'(i), 8'(i), 32'(i), 0), 0, '0));
      steps.push_back(row(mk_req(OP_START, 1, 0, 0, 0, 0), 1,
                          mk_rsp(K_FULL, 0, 0, 1)));
      foreach (steps[i]) send_request(steps[i].req, steps[i].has_answer,
                                      steps[i].answer);

      // random traffic; middle stretch runs without idling
      for (int n = 0; n < 350; n++) begin
         no_idle = (n >= 150 && n < 200);
         rq.delay_ms = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(12);
         rq.timer_id = ($urandom_range(3) == 0) ? 16'($urandom())
                                                : 16'($urandom_range(7));
         rq.handler = 8'($urandom());
         rq.tag = $urandom();
         live = 0;
         for (int i = 0; i < MAX_TIMERS; i++) live += busy_slot[i];
         rq.slot = (live > 0 && $urandom_range(3) != 0) ? chain[$urandom_range(depth_used-1)]
                                                        : 4'($urandom());
         case ($urandom_range(9))
            0, 1, 2: rq.op = OP_START;
            3:       rq.op = OP_CANCEL;
            4:       rq.op = OP_MATCH;
            default: rq.op = OP_TICK;
         endcase
         if (depth_used < 3 && $urandom_range(1)) rq.op = OP_START;
         send_request(rq, 0, '0);
      end
      req_tvalid <= 1'b0;
      no_idle = 0;

      wait_cycles = 0;
      while (pending_rsp.size() != 0 && wait_cycles < 100000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (40) @(posedge clock);
      if (error_count == 0 && pending_rsp.size() == 0)
         $display("delta_list_timer_queue_tb: clean");
      else
         $display("delta_list_timer_queue_tb: errors");
      $finish;
   end

   initial begin
      #20ms;
      $display("delta_list_timer_queue_tb: errors");
      $finish;
   end

endmodule
`default_nettype wire

// ----- delta_list_timer_queue.f -----
hdl/dltq_pkg.sv
hdl/dltq_cell.sv
hdl/delta_list_timer_queue.sv
bench/delta_list_timer_queue_tb.sv
